// ===== sv/bpil_pkg.sv =====
// shared types and constants for the bezier patch index list
// no dependencies; imported by the top level and the bench
package bpil_pkg;

   localparam int HANDLE_W = 32;
   localparam int INDEX_W  = 10;

   // operation codes on the request channel
   typedef enum logic [1:0] {
      ACT_APPEND     = 2'd0,
      ACT_REMOVE_AT  = 2'd1,
      ACT_REMOVE_HDL = 2'd2,
      ACT_READ_SLOT  = 2'd3
   } action_type;

   // result codes on the response channel
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_BEYOND    = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SEARCH,
      STATE_SHIFT,
      STATE_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]          action;
      logic [HANDLE_W-1:0] handle;
      logic [INDEX_W-1:0]  index;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [HANDLE_W-1:0] slot_handle;
      logic [8:0]          point_count;
      logic [6:0]          complete_segments;
      logic [6:0]          total_patches;
      logic [1:0]          trailing_edges;
   } rsp_type;

endpackage

// ===== sv/bpil_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bpil_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bpil_cnt.sv =====
// point counter that also tracks (count-1) div 3 and (count-1) mod 3
// no dependencies; steps by one so no divider is needed
module bpil_cnt #(
   parameter int CW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          inc,
   input  logic          dec,
   output logic [CW-1:0] count,
   output logic [CW-1:0] quo,
   output logic [1:0]    rem
);

   localparam logic [1:0] REM_TOP = 2'd2;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] quo_ff, quo_in;
   logic [1:0]    rem_ff, rem_in;

   // quotient and remainder follow the count one step at a time
   always_comb begin
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (inc) begin
         count_in = count_ff + CW'(1);
         if (count_ff != '0) begin
            if (rem_ff == REM_TOP) begin
               quo_in = quo_ff + CW'(1);
               rem_in = 2'd0;
            end else begin
               rem_in = rem_ff + 2'd1;
            end
         end
      end else if (dec) begin
         count_in = count_ff - CW'(1);
         if (count_ff != CW'(1)) begin
            if (rem_ff == 2'd0) begin
               quo_in = quo_ff - CW'(1);
               rem_in = REM_TOP;
            end else begin
               rem_in = rem_ff - 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         quo_ff   <= '0;
         rem_ff   <= '0;
      end else begin
         count_ff <= count_in;
         quo_ff   <= quo_in;
         rem_ff   <= rem_in;
      end
   end

   assign count = count_ff;
   assign quo   = quo_ff;
   assign rem   = rem_ff;

endmodule

// ===== sv/bezier_patch_index_list.sv =====
// Ordered list of control-point handles for a chain of cubic segments with
// shared endpoints, with a derived four-index patch list read one slot at a time.
//
// Request channel (req_valid/req_ready, req_data): one beat is one operation:
// append a handle, remove at a list position, remove the first matching handle,
// or read one patch slot. Response channel (rsp_valid/rsp_ready, rsp_data):
// exactly one beat per request, with status and the counts after the operation.
// The handles live in one ram with a single read and a single write port, and
// one sequencer walks it one entry per cycle for search and shift-down.
// req_ready is low while an operation runs. The response sits in an output
// register: a stalled receiver holds it, the next request may start, and its
// result waits in the sequencer until the register frees.
// Reset (synchronous, active high) empties the list; no ram clearing is needed.
// Depends on bpil_pkg, bpil_cnt and bpil_ram.
module bezier_patch_index_list #(
   parameter int MAX_POINTS  = 256,
   parameter int HANDLE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bpil_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bpil_pkg::rsp_type rsp_data
);

   import bpil_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int SW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
   localparam int XW = ((CW > INDEX_W) ? CW : INDEX_W) + 2;

   state_type       state_ff, state_in;
   logic [CW-1:0]   ptr_ff, ptr_in;
   logic            pend_ff, pend_in;
   logic [SW-1:0]   hdl_ff, hdl_in;
   logic [1:0]      act_ff, act_in;
   logic [1:0]      stat_ff, stat_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_wa, ram_ra;
   logic [SW-1:0]   ram_wd, ram_rd;

   logic            cnt_inc, cnt_dec;
   logic [CW-1:0]   count, quo;
   logic [1:0]      rem;

   logic            req_fire, out_free, issue, search_hit, full, idx_bad;
   logic [SW-1:0]   req_hdl;
   logic [XW-1:0]   patch_x, slot_addr_x;
   logic [1:0]      slot_k, slot_kk;
   logic            in_full, in_trail, slot_ok;
   logic [CW-1:0]   total;

   bpil_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   bpil_cnt #(
      .CW (CW)
   ) u_cnt (
      .clock (clock),
      .reset (reset),
      .inc   (cnt_inc),
      .dec   (cnt_dec),
      .count (count),
      .quo   (quo),
      .rem   (rem)
   );

   // handshake and shared compares
   assign req_ready  = (state_ff == STATE_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_hdl    = req_data.handle[SW-1:0];
   assign issue      = ptr_ff < count;
   assign search_hit = pend_ff && (ram_rd == hdl_ff);
   assign full       = (count == CW'(MAX_POINTS));
   assign idx_bad    = XW'(req_data.index) >= XW'(count);

   // patch slot to list position
   assign patch_x     = XW'(req_data.index[INDEX_W-1:2]);
   assign slot_k      = req_data.index[1:0];
   assign in_full     = patch_x < XW'(quo);
   assign in_trail    = (patch_x == XW'(quo)) && (rem != 2'd0);
   assign slot_ok     = in_full || in_trail;
   assign slot_kk     = (in_full || slot_k < rem) ? slot_k : rem;
   assign slot_addr_x = (patch_x << 1) + patch_x + XW'(slot_kk);
   assign total       = quo + CW'(rem != 2'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (req_fire) begin
               case (req_data.action)
                  ACT_REMOVE_AT:  state_in = idx_bad ? STATE_FINISH : STATE_SHIFT;
                  ACT_REMOVE_HDL: state_in = STATE_SEARCH;
                  default:        state_in = STATE_FINISH;
               endcase
            end
         end
         STATE_SEARCH: begin
            if (search_hit) begin
               state_in = STATE_SHIFT;
            end else if (!issue && !pend_ff) begin
               state_in = STATE_FINISH;
            end
         end
         STATE_SHIFT: begin
            if (!issue) begin
               state_in = STATE_FINISH;
            end
         end
         STATE_FINISH: begin
            if (out_free) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   // sequencer outputs and datapath
   always_comb begin
      ram_we       = 1'b0;
      ram_wa       = AW'(count);
      ram_wd       = hdl_ff;
      ram_re       = 1'b0;
      ram_ra       = AW'(ptr_ff);
      cnt_inc      = 1'b0;
      cnt_dec      = 1'b0;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      hdl_in       = hdl_ff;
      act_in       = act_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (req_fire) begin
               hdl_in  = req_hdl;
               act_in  = req_data.action;
               stat_in = STAT_OK;
               ptr_in  = '0;
               case (req_data.action)
                  ACT_APPEND: begin
                     if (full) begin
                        stat_in = STAT_FULL;
                     end else begin
                        ram_we  = 1'b1;
                        ram_wd  = req_hdl;
                        cnt_inc = 1'b1;
                     end
                  end
                  ACT_REMOVE_AT: begin
                     if (idx_bad) begin
                        stat_in = STAT_NOT_FOUND;
                     end else begin
                        ptr_in = CW'(req_data.index) + CW'(1);
                     end
                  end
                  ACT_READ_SLOT: begin
                     if (slot_ok) begin
                        ram_re = 1'b1;
                        ram_ra = AW'(slot_addr_x);
                     end else begin
                        stat_in = STAT_BEYOND;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // scan from the head, one compare per read beat
         STATE_SEARCH: begin
            if (!search_hit) begin
               if (issue) begin
                  ram_re  = 1'b1;
                  ptr_in  = ptr_ff + CW'(1);
                  pend_in = 1'b1;
               end else if (!pend_ff) begin
                  stat_in = STAT_NOT_FOUND;
               end
            end
         end
         // read entry ptr, write it one place lower in the next cycle
         STATE_SHIFT: begin
            if (pend_ff) begin
               ram_we = 1'b1;
               ram_wa = AW'(ptr_ff - CW'(2));
               ram_wd = ram_rd;
            end
            if (issue) begin
               ram_re  = 1'b1;
               ptr_in  = ptr_ff + CW'(1);
               pend_in = 1'b1;
            end else begin
               cnt_dec = 1'b1;
            end
         end
         STATE_FINISH: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.status            = stat_ff;
               rsp_data_in.slot_handle       = '0;
               if (act_ff == ACT_READ_SLOT && stat_ff == STAT_OK) begin
                  rsp_data_in.slot_handle = HANDLE_W'(ram_rd);
               end
               rsp_data_in.point_count       = 9'(count);
               rsp_data_in.complete_segments = 7'(quo);
               rsp_data_in.total_patches     = 7'(total);
               rsp_data_in.trailing_edges    = rem;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operation and response payload
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      hdl_ff      <= hdl_in;
      act_ff      <= act_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== bench/tb_bezier_patch_index_list.sv =====
// self-checking bench for the bezier patch index list: a directed table, then
// random edit sequences checked beat by beat against an in-bench list model
// depends on bpil_pkg and bezier_patch_index_list
`timescale 1ns / 100ps

module tb_bezier_patch_index_list;
   import bpil_pkg::*;

   localparam int MAX_PTS    = 256;
   localparam int LIMIT      = 2_000_000;
   localparam int TAIL_WAIT  = 600;
   localparam int PER_PHASE  = 470;
   localparam int PRINT_CAP  = 100;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } plan_row;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // list model state
   logic [HANDLE_W-1:0] list_mem [MAX_PTS];
   int unsigned         list_len = 0;
   rsp_type             pending_rsp [$];

   int unsigned tx_idle_pct = 9;
   int unsigned rx_idle_pct = 54;
   int unsigned fail_count  = 0;
   int unsigned rsp_seen    = 0;
   int unsigned cycle_count = 0;

   bezier_patch_index_list dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("[bezier_patch_index_list] ERROR");
         $finish;
      end
   end

   function automatic int unsigned seg_cnt(input int unsigned n);
      return n >= 4 ? (n - 1) / 3 : 0;
   endfunction

   function automatic int unsigned trail_cnt(input int unsigned n);
      return n >= 2 ? (n - 1) % 3 : 0;
   endfunction

   function automatic req_type mk(input action_type a, input logic [31:0] h,
                                  input logic [9:0] idx);
      req_type r;
      r.action = a;
      r.handle = h;
      r.index  = idx;
      return r;
   endfunction

   function automatic rsp_type rs(input status_type s, input logic [31:0] h,
                                  input int unsigned cnt, input int unsigned segs,
                                  input int unsigned tot, input int unsigned trail);
      rsp_type o;
      o.status            = s;
      o.slot_handle       = h;
      o.point_count       = 9'(cnt);
      o.complete_segments = 7'(segs);
      o.total_patches     = 7'(tot);
      o.trailing_edges    = 2'(trail);
      return o;
   endfunction

   // apply one edit to the list model and return the response it implies
   function automatic rsp_type apply_edit(input req_type r);
      rsp_type     o;
      int          pos;
      int          i;
      int unsigned segs, trail, p, k;
      o   = '0;
      pos = -1;
      case (r.action)
         ACT_APPEND: begin
            if (list_len >= MAX_PTS) begin
               o.status = STAT_FULL;
            end else begin
               list_mem[list_len] = r.handle;
               list_len++;
            end
         end
         ACT_REMOVE_AT: begin
            if (32'(r.index) < list_len) pos = int'(r.index);
            else o.status = STAT_NOT_FOUND;
         end
         ACT_REMOVE_HDL: begin
            // scan downward so the first match wins
            for (i = int'(list_len) - 1; i >= 0; i--) begin
               if (list_mem[i] == r.handle) pos = i;
            end
            if (pos < 0) o.status = STAT_NOT_FOUND;
         end
         default: begin
            // slot s is entry s mod 4 of patch s div 4; partial patch padded
            segs  = seg_cnt(list_len);
            trail = trail_cnt(list_len);
            p     = 32'(r.index) / 4;
            k     = 32'(r.index) % 4;
            if (p < segs) begin
               o.slot_handle = list_mem[(3 * p + k) % MAX_PTS];
            end else if (p == segs && trail > 0) begin
               o.slot_handle = list_mem[(3 * segs + (k < trail ? k : trail)) % MAX_PTS];
            end else begin
               o.status = STAT_BEYOND;
            end
         end
      endcase
      // shift later entries down over the removed one
      if (pos >= 0) begin
         for (i = pos; i < int'(list_len) - 1; i++) list_mem[i] = list_mem[i + 1];
         list_len--;
      end
      segs  = seg_cnt(list_len);
      trail = trail_cnt(list_len);
      o.point_count       = 9'(list_len);
      o.complete_segments = 7'(segs);
      o.total_patches     = 7'(segs + (trail > 0 ? 1 : 0));
      o.trailing_edges    = 2'(trail);
      return o;
   endfunction

   // mostly well-formed edits on the current list, some pure noise
   function automatic req_type random_edit();
      req_type     r;
      int unsigned app_pct, tot;
      r.action = 2'($urandom);
      r.handle = $urandom;
      r.index  = 10'($urandom);
      if ($urandom_range(0, 99) < 10) return r;
      app_pct = list_len < 6 ? 60 : (list_len > 48 ? 20 : 40);
      if ($urandom_range(0, 99) < app_pct) begin
         r.action = ACT_APPEND;
         if (list_len != 0 && $urandom_range(0, 9) == 0)
            r.handle = list_mem[$urandom_range(0, list_len - 1)];
         else if ($urandom_range(0, 4) == 0)
            r.handle = $urandom_range(0, 7);
      end else begin
         case ($urandom_range(0, 2))
            0: begin
               r.action = ACT_REMOVE_AT;
               if (list_len == 0 || $urandom_range(0, 7) == 0) r.index = 10'(list_len);
               else r.index = 10'($urandom_range(0, list_len - 1));
            end
            1: begin
               r.action = ACT_REMOVE_HDL;
               if (list_len != 0 && $urandom_range(0, 5) != 0)
                  r.handle = list_mem[$urandom_range(0, list_len - 1)];
               else
                  r.handle = $urandom_range(0, 7);
            end
            default: begin
               r.action = ACT_READ_SLOT;
               tot      = seg_cnt(list_len) + (trail_cnt(list_len) > 0 ? 1 : 0);
               r.index  = 10'($urandom_range(0, 4 * tot + 4));
            end
         endcase
      end
      return r;
   endfunction

   // one line per failure, printing capped
   task automatic report_error(input string msg);
      if (fail_count < PRINT_CAP) $display("mismatch: %s", msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("beat %0d %s got 0x%0h want 0x%0h",
                                rsp_seen, name, got, want));
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         report_error($sformatf("beat %0d arrived with nothing pending", rsp_seen));
      end else begin
         want = pending_rsp.pop_front();
         compare_field("status", 32'(got.status), 32'(want.status));
         compare_field("slot_handle", got.slot_handle, want.slot_handle);
         compare_field("point_count", 32'(got.point_count), 32'(want.point_count));
         compare_field("complete_segments", 32'(got.complete_segments),
                       32'(want.complete_segments));
         compare_field("total_patches", 32'(got.total_patches),
                       32'(want.total_patches));
         compare_field("trailing_edges", 32'(got.trailing_edges),
                       32'(want.trailing_edges));
      end
      rsp_seen++;
   endtask

   // drive one request beat; optionally hold off until all responses are back
   task automatic send_beat(input req_type item, input bit hold_off,
                            input bit typed, input rsp_type given);
      rsp_type want;
      if (hold_off || $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ((hold_off && pending_rsp.size() != 0) ||
                $urandom_range(0, 99) < tx_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = apply_edit(item);
      if (typed) want = given;
      pending_rsp = {pending_rsp, want};
   endtask

   // response side: check accepted beats, stall at random
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_beat(rsp_data);
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // stimulus
   initial begin
      plan_row     plan [24];
      int unsigned n, phase;
      plan = '{
         '{mk(ACT_READ_SLOT, 32'h0, 10'd0), 1'b1, rs(STAT_BEYOND, 32'h0, 0, 0, 0, 0)},
         '{mk(ACT_REMOVE_AT, 32'h0, 10'd0), 1'b1, rs(STAT_NOT_FOUND, 32'h0, 0, 0, 0, 0)},
         '{mk(ACT_REMOVE_HDL, 32'h0, 10'd0), 1'b1, rs(STAT_NOT_FOUND, 32'h0, 0, 0, 0, 0)},
         '{mk(ACT_APPEND, 32'hFFFF_FFFF, 10'd0), 1'b1, rs(STAT_OK, 32'h0, 1, 0, 0, 0)},
         '{mk(ACT_READ_SLOT, 32'h0, 10'd0), 1'b1, rs(STAT_BEYOND, 32'h0, 1, 0, 0, 0)},
         '{mk(ACT_APPEND, 32'h0, 10'd1023), 1'b1, rs(STAT_OK, 32'h0, 2, 0, 1, 1)},
         '{mk(ACT_READ_SLOT, 32'h0, 10'd3), 1'b0, '0},
         '{mk(ACT_READ_SLOT, 32'h0, 10'd0), 1'b0, '0},
         '{mk(ACT_READ_SLOT, 32'h0, 10'd4), 1'b1, rs(STAT_BEYOND, 32'h0, 2, 0, 1, 1)},
         '{mk(ACT_APPEND, 32'hA5A5_5A5A, 10'd0), 1'b0, '0},
         '{mk(ACT_APPEND, 32'h0000_0001, 10'd0), 1'b0, '0},
         '{mk(ACT_READ_SLOT, 32'h0, 10'd3), 1'b0, '0},
         '{mk(ACT_READ_SLOT, 32'h0, 10'd4), 1'b0, '0},
         '{mk(ACT_APPEND, 32'h8000_0000, 10'd0), 1'b0, '0},
         '{mk(ACT_APPEND, 32'hFFFF_FFFF, 10'd0), 1'b0, '0},
         '{mk(ACT_READ_SLOT, 32'h0, 10'd7), 1'b0, '0},
         '{mk(ACT_READ_SLOT, 32'h0, 10'd1023), 1'b1, rs(STAT_BEYOND, 32'h0, 6, 1, 2, 2)},
         '{mk(ACT_REMOVE_HDL, 32'hFFFF_FFFF, 10'd0), 1'b0, '0},
         '{mk(ACT_REMOVE_AT, 32'h0, 10'd1023), 1'b1, rs(STAT_NOT_FOUND, 32'h0, 5, 1, 2, 1)},
         '{mk(ACT_REMOVE_AT, 32'h0, 10'd4), 1'b0, '0},
         '{mk(ACT_REMOVE_AT, 32'h0, 10'd0), 1'b0, '0},
         '{mk(ACT_REMOVE_HDL, 32'h1234_5678, 10'd0), 1'b0, '0},
         '{mk(ACT_READ_SLOT, 32'h0, 10'd2), 1'b0, '0},
         '{mk(ACT_REMOVE_HDL, 32'h8000_0000, 10'd0), 1'b0, '0}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[i]) send_beat(plan[i].beat, 1'b0, plan[i].typed, plan[i].want);

      // random phases with different idle mixes
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 9;  rx_idle_pct = 54; end
            1: begin tx_idle_pct = 54; rx_idle_pct = 9;  end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         if (phase == 1) begin
            // fill to the top, hit the full store, then edit at the far end
            while (list_len < MAX_PTS) begin
               if (list_len != 0 && $urandom_range(0, 15) == 0)
                  send_beat(mk(ACT_APPEND, list_mem[$urandom_range(0, list_len - 1)],
                               10'd0), 1'b0, 1'b0, '0);
               else
                  send_beat(mk(ACT_APPEND, $urandom, 10'($urandom)), 1'b0, 1'b0, '0);
            end
            repeat (3) send_beat(mk(ACT_APPEND, $urandom, 10'($urandom)), 1'b0, 1'b0, '0);
            send_beat(mk(ACT_READ_SLOT, 32'h0, 10'd339), 1'b0, 1'b0, '0);
            send_beat(mk(ACT_READ_SLOT, 32'h0, 10'd340), 1'b0, 1'b0, '0);
            send_beat(mk(ACT_READ_SLOT, 32'h0, 10'd1023), 1'b0, 1'b0, '0);
            send_beat(mk(ACT_REMOVE_HDL, list_mem[MAX_PTS - 1], 10'd0), 1'b0, 1'b0, '0);
            send_beat(mk(ACT_READ_SLOT, 32'h0, 10'd339), 1'b0, 1'b0, '0);
            send_beat(mk(ACT_REMOVE_AT, 32'h0, 10'(list_len - 1)), 1'b0, 1'b0, '0);
            send_beat(mk(ACT_REMOVE_AT, 32'h0, 10'd0), 1'b0, 1'b0, '0);
            send_beat(mk(ACT_REMOVE_HDL, $urandom, 10'd0), 1'b0, 1'b0, '0);
            repeat (4) send_beat(mk(ACT_APPEND, $urandom, 10'($urandom)), 1'b0, 1'b0, '0);
            // drain cheaply from the top
            while (list_len > 40)
               send_beat(mk(ACT_REMOVE_AT, $urandom,
                            10'(list_len - 1 - $urandom_range(0, 3))),
                         1'b0, 1'b0, '0);
         end
         for (n = 0; n < PER_PHASE; n++)
            send_beat(random_edit(), n == 0 || $urandom_range(0, 99) == 0, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // wait out the responses, then a quiet tail
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("[bezier_patch_index_list] OK");
      end else begin
         $display("[bezier_patch_index_list] ERROR");
      end
      $finish;
   end

endmodule
